FILE: hw/rtl/pkhm_pkg.sv
// Package for the pressed-key set tracker: widths, event codes, status codes,
// FSM states and the control struct broadcast along the slot cell chain.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pkhm_pkg;

  // Field widths
  localparam int unsigned TypeW  = 5;
  localparam int unsigned CodeW  = 10;
  localparam int unsigned ValueW = 2;
  localparam int unsigned HeldW  = 5;
  localparam int unsigned StatW  = 2;

  // Stream data widths (packed fields rounded up to whole bytes)
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  // Default slot count
  localparam int unsigned MaxKeysDef = 16;

  // Event decode
  localparam logic [TypeW-1:0]  KeyEventType    = 5'd1;
  localparam logic [CodeW-1:0]  CodeToolFinger  = 10'd325;
  localparam logic [CodeW-1:0]  CodeTouch       = 10'd330;
  localparam logic [CodeW-1:0]  CodeToolDblTap  = 10'd333;
  localparam logic [CodeW-1:0]  CodeToolTrplTap = 10'd334;
  localparam logic [ValueW-1:0] ValRelease      = 2'd0;
  localparam logic [ValueW-1:0] ValPress        = 2'd1;

  // Hotkey register reset values
  localparam logic [CodeW-1:0] HotkeyFirstRst  = 10'd56;
  localparam logic [CodeW-1:0] HotkeySecondRst = 10'd31;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegHotkeyFirst  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegHotkeySecond = 1'd1;

  typedef enum logic [StatW-1:0] {
    ST_DONE     = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_NOCHANGE = 2'd2,
    ST_FULL     = 2'd3
  } op_status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_EVAL = 2'b10
  } fsm_state_e;

  // Command broadcast to every slot cell
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             add;
    logic             rem;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pressed_key_set_hotkey_match_unit.sv
// Top level of the pressed-key set tracker with two-key hotkey detection.
// Instantiates a row of pkhm_cell slots; depends on pkhm_pkg.
//
//   Channel  | Dir | Fields (low bit up)
//   s_axis   | in  | tdata: event_type[4:0], key_code[14:5], key_value[16:15]
//   m_axis   | out | tdata: held_count[4:0], set_changed[5], hotkey_hit[6],
//            |     |        op_status[8:7]
//   cfg      | in  | idx 0 hotkey_first, idx 1 hotkey_second
//
// Each item is captured in FSM_IDLE; FSM_EVAL then does the cell-chain compare,
// the slot update and the result. The chain's match ripple sets the path.
// A waiting result holds the update cycle; one new item is still taken while
// it waits, then the input stalls until the result is accepted.
// Reset clears the held count and loads the hotkey pair (56, 31).
`timescale 1ns / 1ps
`default_nettype none

module pressed_key_set_hotkey_match_unit
  import pkhm_pkg::*;
#(
  parameter int unsigned MAX_KEYS = MaxKeysDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input event stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // event_type, key_code, key_value
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // held_count, set_changed,
                                                   // hotkey_hit, op_status
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CodeW-1:0]    cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_KEYS + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(MAX_KEYS);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] CntTwo  = CntW'(2);

  fsm_state_e state_q, state_d;

  logic [CodeW-1:0]  hk_first_q, hk_second_q;
  logic [TypeW-1:0]  ev_type_q;
  logic [CodeW-1:0]  ev_code_q;
  logic [ValueW-1:0] ev_val_q;
  logic [CntW-1:0]   count_q, count_d;

  logic              out_valid_q, out_valid_d;
  logic [HeldW-1:0]  out_held_q;
  logic              out_chg_q, out_hit_q;
  op_status_e        out_stat_q;

  logic              in_fire, go;
  logic              is_key, is_press, is_release, found, full;
  logic              add_en, rem_en, changed, hit;
  op_status_e        status;
  cell_ctrl_t        ctrl;
  logic [CntW+HeldW-1:0] held_ext;

  logic [CodeW-1:0]  cell_key [MAX_KEYS];
  logic [CodeW-1:0]  cell_key_nx [MAX_KEYS];
  logic [MAX_KEYS-1:0] match;
  logic [MAX_KEYS:0]   below;

  // Handshake and sequencing
  assign s_axis_tready = (state_q == FSM_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign go            = (state_q == FSM_EVAL) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (in_fire) state_d = FSM_EVAL;
      FSM_EVAL: if (go) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // Event decode
  assign is_key = (ev_type_q == KeyEventType) &&
                  (ev_code_q != CodeToolFinger) && (ev_code_q != CodeTouch) &&
                  (ev_code_q != CodeToolDblTap) && (ev_code_q != CodeToolTrplTap);
  assign is_press   = is_key && (ev_val_q == ValPress);
  assign is_release = is_key && (ev_val_q == ValRelease);
  assign found      = |match;
  assign full       = (count_q >= CntFull);
  assign add_en     = go && is_press && !found && !full;
  assign rem_en     = go && is_release && found;
  assign changed    = add_en || rem_en;

  assign ctrl.code = ev_code_q;
  assign ctrl.add  = add_en;
  assign ctrl.rem  = rem_en;

  // Cell chain
  assign below[0] = 1'b0;
  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    logic [CodeW-1:0] up_key;
    if (g == MAX_KEYS - 1) begin : g_top
      assign up_key = '0;
    end else begin : g_mid
      assign up_key = cell_key[g+1];
    end
    pkhm_cell #(
      .CntW (CntW),
      .Idx  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .up_key_i    (up_key),
      .hit_below_i (below[g]),
      .key_o       (cell_key[g]),
      .key_next_o  (cell_key_nx[g]),
      .match_o     (match[g]),
      .hit_below_o (below[g+1])
    );
  end

  // Count update
  always_comb begin
    count_d = count_q;
    if (add_en) begin
      count_d = count_q + CntOne;
    end else if (rem_en) begin
      count_d = count_q - CntOne;
    end
  end

  // Status and hotkey check on the updated set
  always_comb begin
    status = ST_IGNORED;
    if (is_press) begin
      if (found)     status = ST_NOCHANGE;
      else if (full) status = ST_FULL;
      else           status = ST_DONE;
    end else if (is_release) begin
      status = found ? ST_DONE : ST_NOCHANGE;
    end
  end

  assign hit = changed && (count_d == CntTwo) &&
               (((cell_key_nx[0] == hk_first_q) && (cell_key_nx[1] == hk_second_q)) ||
                ((cell_key_nx[0] == hk_second_q) && (cell_key_nx[1] == hk_first_q)));

  assign held_ext = {{HeldW{1'b0}}, count_d};

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (go) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      hk_first_q  <= HotkeyFirstRst;
      hk_second_q <= HotkeySecondRst;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == RegHotkeyFirst)) begin
        hk_first_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == RegHotkeySecond)) begin
        hk_second_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_type_q <= s_axis_tdata[TypeW-1:0];
      ev_code_q <= s_axis_tdata[TypeW+CodeW-1:TypeW];
      ev_val_q  <= s_axis_tdata[TypeW+CodeW+ValueW-1:TypeW+CodeW];
    end
    if (go) begin
      out_held_q <= held_ext[HeldW-1:0];
      out_chg_q  <= changed;
      out_hit_q  <= hit;
      out_stat_q <= status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-HeldW-2-StatW){1'b0}},
                          out_stat_q, out_hit_q, out_chg_q, out_held_q};

endmodule

`default_nettype wire

FILE: hw/rtl/pkhm_cell.sv
// One slot of the held-key chain: stores a key code, compares it to the
// event code and shifts down from its upper neighbor on removal.
// Depends on pkhm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pkhm_cell
  import pkhm_pkg::*;
#(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  wire logic             clk_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [CntW-1:0]  count_i,
  input  wire logic [CodeW-1:0] up_key_i,     // key of the next cell up
  input  wire logic             hit_below_i,  // match somewhere below
  output logic [CodeW-1:0]      key_o,
  output logic [CodeW-1:0]      key_next_o,
  output logic                  match_o,
  output logic                  hit_below_o
);

  localparam logic [CntW-1:0] MyIdx = CntW'(Idx);

  logic [CodeW-1:0] key_q, key_d;
  logic             occ;
  logic             shift;

  // Occupied slots form the prefix below the count
  assign occ         = MyIdx < count_i;
  assign match_o     = occ && (key_q == ctrl_i.code);
  assign hit_below_o = hit_below_i | match_o;
  assign shift       = ctrl_i.rem && occ && hit_below_o;

  // Append at the first free slot, close the gap on removal
  always_comb begin
    key_d = key_q;
    if (ctrl_i.add && (MyIdx == count_i)) begin
      key_d = ctrl_i.code;
    end else if (shift) begin
      key_d = up_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o      = key_q;
  assign key_next_o = key_d;

endmodule

`default_nettype wire

FILE: verif/pressed_key_set_hotkey_match_unit_tb.sv
// Self-checking testbench for the pressed-key set tracker with hotkey detection.
// Predicts each result from its own model of the held-key set; needs pkhm_pkg and the unit.
`timescale 1ns / 1ps

module pressed_key_set_hotkey_match_unit_tb;
  import pkhm_pkg::*;

  localparam int unsigned MaxKeys    = MaxKeysDef;
  localparam int unsigned StallLimit = 5000;  // cycles with no item moving
  localparam int unsigned LongHold   = 400;   // long output back-pressure
  localparam int unsigned ChgBit     = HeldW;
  localparam int unsigned HitBit     = HeldW + 1;
  localparam int unsigned StatLo     = HeldW + 2;
  localparam int unsigned InPadW     = InDataW - TypeW - CodeW - ValueW;

  // key values the unit ignores
  localparam logic [ValueW-1:0] ValRepeat   = 2'd2;
  localparam logic [ValueW-1:0] ValReserved = 2'd3;

  typedef struct packed {
    logic [HeldW-1:0] held;
    logic             changed;
    logic             hit;
    op_status_e       status;
  } key_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // event_type, key_code, key_value
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // held_count, set_changed, hotkey_hit, op_status
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CodeW-1:0]    cfg_data_i;

  // predicted held-key set and hotkey pair
  logic [CodeW-1:0] held_keys [MaxKeys];
  int unsigned      held_n;
  logic [CodeW-1:0] hk_first;
  logic [CodeW-1:0] hk_second;

  // expected results, oldest first
  key_result_t pending_results[$];
  key_result_t want_res;

  logic [CodeW-1:0] touch_codes [4] = '{CodeToolFinger, CodeTouch, CodeToolDblTap,
                                        CodeToolTrplTap};

  bit          send_idle;
  bit          recv_idle;
  bit          hold_req;
  bit          field_bad;
  int unsigned events_sent;
  int unsigned mismatches;
  int unsigned hotkey_hits;
  int unsigned full_refusals;
  int unsigned long_holds;
  int unsigned quiet_cycles;

  pressed_key_set_hotkey_match_unit #(
    .MAX_KEYS(MaxKeys)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one event to the predicted set and return the result it should give
  function automatic key_result_t track_key_event(input logic [TypeW-1:0]  etype,
                                                  input logic [CodeW-1:0]  code,
                                                  input logic [ValueW-1:0] val);
    key_result_t r;
    int          pos;
    int unsigned i;
    r.changed = 1'b0;
    r.hit     = 1'b0;
    r.status  = ST_IGNORED;
    pos       = -1;
    for (i = 0; i < held_n; i++) begin
      if (pos < 0 && held_keys[i] == code) pos = i;
    end
    if (etype == KeyEventType && code != CodeTouch && code != CodeToolFinger &&
        code != CodeToolDblTap && code != CodeToolTrplTap) begin
      if (val == ValPress) begin
        // duplicate is checked ahead of the full test
        if (pos >= 0) begin
          r.status = ST_NOCHANGE;
        end else if (held_n >= MaxKeys) begin
          r.status = ST_FULL;
        end else begin
          held_keys[held_n] = code;
          held_n++;
          r.changed = 1'b1;
          r.status  = ST_DONE;
        end
      end else if (val == ValRelease) begin
        if (pos < 0) begin
          r.status = ST_NOCHANGE;
        end else begin
          // swap-remove: last entry fills the hole
          held_n--;
          held_keys[pos] = held_keys[held_n];
          r.changed = 1'b1;
          r.status  = ST_DONE;
        end
      end
    end
    if (r.changed && held_n == 2) begin
      r.hit = (held_keys[0] == hk_first && held_keys[1] == hk_second) ||
              (held_keys[0] == hk_second && held_keys[1] == hk_first);
    end
    r.held = HeldW'(held_n);
    return r;
  endfunction

  // Offer one event; entered and left at a falling edge with tvalid still high
  task automatic send_key_event(input logic [TypeW-1:0]  etype,
                                input logic [CodeW-1:0]  code,
                                input logic [ValueW-1:0] val);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{InPadW{1'b0}}, val, code, etype};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(track_key_event(etype, code, val));
    events_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering and let every outstanding result come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (3) @(negedge clk_i);
  endtask

  // Program both hotkey registers while the unit is idle
  task automatic set_hotkey_pair(input logic [CodeW-1:0] a, input logic [CodeW-1:0] b);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegHotkeyFirst;
    cfg_data_i <= a;
    @(negedge clk_i);
    cfg_idx_i  <= RegHotkeySecond;
    cfg_data_i <= b;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    hk_first  = a;
    hk_second = b;
  endtask

  task automatic release_all_keys();
    while (held_n != 0)
      send_key_event(KeyEventType, held_keys[$urandom_range(0, held_n - 1)], ValRelease);
  endtask

  // Non-key types, touchpad codes and ignored values leave the set alone
  task automatic test_filtered_events();
    int i;
    send_key_event(5'd0, 10'd30, ValPress);
    send_key_event(5'd31, 10'd30, ValPress);
    for (i = 0; i < 4; i++)
      send_key_event(KeyEventType, touch_codes[i], (i % 2 == 0) ? ValPress : ValRelease);
    send_key_event(KeyEventType, 10'd30, ValRepeat);
    send_key_event(KeyEventType, 10'd30, ValReserved);
  endtask

  // Plain add/remove plus duplicate press and absent release, at code extremes
  task automatic test_press_release();
    send_key_event(KeyEventType, 10'd0, ValPress);
    send_key_event(KeyEventType, 10'd1023, ValPress);
    send_key_event(KeyEventType, 10'd1023, ValPress);
    send_key_event(KeyEventType, 10'd512, ValRelease);
    send_key_event(KeyEventType, 10'd0, ValRelease);
  endtask

  // Fill every slot, try a new key and a held key, then free a slot and add the new key
  task automatic test_set_full();
    int k;
    k = 101;
    while (held_n < MaxKeys) begin
      send_key_event(KeyEventType, CodeW'(k), ValPress);
      k++;
    end
    send_key_event(KeyEventType, 10'd200, ValPress);
    send_key_event(KeyEventType, 10'd1023, ValPress);
    send_key_event(KeyEventType, 10'd105, ValRelease);
    send_key_event(KeyEventType, 10'd200, ValPress);
  endtask

  // Pair hit in both orders and on a release down to two keys; equal pair never hits
  task automatic test_hotkey_detect();
    set_hotkey_pair(10'd0, 10'd1023);
    release_all_keys();
    send_key_event(KeyEventType, 10'd0, ValPress);
    send_key_event(KeyEventType, 10'd1023, ValPress);
    send_key_event(KeyEventType, 10'd1023, ValPress);
    send_key_event(KeyEventType, 10'd0, ValRelease);
    send_key_event(KeyEventType, 10'd0, ValPress);
    send_key_event(KeyEventType, 10'd44, ValPress);
    send_key_event(KeyEventType, 10'd44, ValRelease);
    release_all_keys();
    set_hotkey_pair(10'd9, 10'd9);
    send_key_event(KeyEventType, 10'd9, ValPress);
    send_key_event(KeyEventType, 10'd9, ValPress);
    send_key_event(KeyEventType, 10'd3, ValPress);
    release_all_keys();
  endtask

  // Mostly press/release traffic over a small code pool, with hotkey chords and noise
  task automatic test_random_traffic(input int unsigned count, input bit with_hold);
    logic [CodeW-1:0] pool [24];
    int unsigned      start;
    int unsigned      pick;
    int unsigned      i;
    bit               hold_done;
    pool[0] = hk_first;
    pool[1] = hk_second;
    for (i = 2; i < 24; i++) pool[i] = CodeW'($urandom_range(0, 1023));
    start     = events_sent;
    hold_done = 1'b0;
    while (events_sent - start < count) begin
      if (with_hold && !hold_done && events_sent - start >= count / 3) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_key_event(TypeW'($urandom_range(0, 31)), CodeW'($urandom_range(0, 1023)),
                       ValueW'($urandom_range(0, 3)));
      end else if (pick < 10) begin
        send_key_event(KeyEventType, touch_codes[$urandom_range(0, 3)],
                       ValueW'($urandom_range(0, 3)));
      end else if (pick < 14) begin
        send_key_event(KeyEventType, pool[$urandom_range(0, 23)],
                       $urandom_range(0, 1) ? ValRepeat : ValReserved);
      end else if (pick < 20) begin
        // chord: clear the set, then press the pair in either order
        release_all_keys();
        if ($urandom_range(0, 1)) begin
          send_key_event(KeyEventType, hk_first, ValPress);
          send_key_event(KeyEventType, hk_second, ValPress);
        end else begin
          send_key_event(KeyEventType, hk_second, ValPress);
          send_key_event(KeyEventType, hk_first, ValPress);
        end
      end else if ($urandom_range(0, 99) < 55) begin
        send_key_event(KeyEventType, pool[$urandom_range(0, 23)], ValPress);
      end else if (held_n != 0 && $urandom_range(0, 99) < 80) begin
        send_key_event(KeyEventType, held_keys[$urandom_range(0, held_n - 1)], ValRelease);
      end else begin
        send_key_event(KeyEventType, pool[$urandom_range(0, 23)], ValRelease);
      end
    end
  endtask

  // Result sink: random stall per item, one long hold on request
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = recv_idle ? $urandom_range(0, 11) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LongHold;
        long_holds++;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result %h with nothing expected", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want_res  = pending_results.pop_front();
        field_bad = 1'b0;
        if (m_axis_tdata[HeldW-1:0] != want_res.held) begin
          $display("%0t: held_count expected %0d got %0d", $time, want_res.held,
                   m_axis_tdata[HeldW-1:0]);
          field_bad = 1'b1;
        end
        if (m_axis_tdata[ChgBit] != want_res.changed) begin
          $display("%0t: set_changed expected %0b got %0b", $time, want_res.changed,
                   m_axis_tdata[ChgBit]);
          field_bad = 1'b1;
        end
        if (m_axis_tdata[HitBit] != want_res.hit) begin
          $display("%0t: hotkey_hit expected %0b got %0b", $time, want_res.hit,
                   m_axis_tdata[HitBit]);
          field_bad = 1'b1;
        end
        if (m_axis_tdata[StatLo+:StatW] != want_res.status) begin
          $display("%0t: op_status expected %0d got %0d", $time, want_res.status,
                   m_axis_tdata[StatLo+:StatW]);
          field_bad = 1'b1;
        end
        if (field_bad) mismatches++;
        if (want_res.hit) hotkey_hits++;
        if (want_res.status == ST_FULL) full_refusals++;
      end
    end
  end

  // Watchdog: abort when no item moves on either stream for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegHotkeyFirst;
    cfg_data_i    = '0;
    hk_first      = HotkeyFirstRst;
    hk_second     = HotkeySecondRst;
    held_n        = 0;
    send_idle     = 1'b1;
    recv_idle     = 1'b1;
    hold_req      = 1'b0;
    events_sent   = 0;
    mismatches    = 0;
    hotkey_hits   = 0;
    full_refusals = 0;
    long_holds    = 0;
    quiet_cycles  = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_filtered_events();
    test_press_release();
    test_set_full();
    test_random_traffic(300, 1'b1);
    test_hotkey_detect();

    // equal pair, output never stalls
    recv_idle = 1'b0;
    test_random_traffic(200, 1'b0);

    set_hotkey_pair(10'd1023, 10'd0);
    send_idle = 1'b0;
    recv_idle = 1'b1;
    test_random_traffic(250, 1'b0);

    set_hotkey_pair(HotkeyFirstRst, HotkeySecondRst);
    send_idle = 1'b1;
    recv_idle = 1'b0;
    test_random_traffic(200, 1'b0);

    set_hotkey_pair(CodeW'($urandom_range(0, 1023)), CodeW'($urandom_range(0, 1023)));
    recv_idle = 1'b1;
    test_random_traffic(250, 1'b1);

    // drain, then let the pipeline settle
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d key events over five hotkey settings: %0d hotkey hits, %0d full-set refusals,",
             events_sent, hotkey_hits, full_refusals);
    $display("%0d long output holds, %0d mismatching results.", long_holds, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pkhm_pkg.sv
hw/rtl/pkhm_cell.sv
hw/rtl/pressed_key_set_hotkey_match_unit.sv
verif/pressed_key_set_hotkey_match_unit_tb.sv
